[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in every cycle out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pip_pkg.sv]
// ----------------------------------------------------------------------------
// pip_pkg
// Shared widths, opcodes and controller/datapath interface types for the
// point-in-polygon geofence block.
// ----------------------------------------------------------------------------
package pip_pkg;

	localparam int COORD_W          = 31;
	localparam int DIFF_W           = COORD_W + 1;
	localparam int PROD_W           = 2 * DIFF_W;
	localparam int IDX_W            = 4;
	localparam int CNT_W            = 5;
	localparam int MAX_VERTICES_DEF = 16;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic start_query; // latch query point, preset outside flag
		logic wr_en;       // write vertex store
		logic rd_en;       // read one vertex
		logic rd_edge;     // this read closes an edge with the previous vertex
	} pip_cmd_t;

	typedef struct packed {
		logic pipe_busy;   // edge pipeline still holds work
	} pip_stat_t;

endpackage

[design/pip_datapath.sv]
// ----------------------------------------------------------------------------
// pip_datapath
// Vertex store, query point registers and the edge pipeline: read, differences,
// cross products, crossing decision and outside flag.
// ----------------------------------------------------------------------------
module pip_datapath #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int AW           = $clog2(MAX_VERTICES)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pip_pkg::pip_cmd_t                  cmd,
	input  logic [AW-1:0]                      wr_addr,
	input  logic [AW-1:0]                      rd_addr,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
	output pip_pkg::pip_stat_t                 stat,
	output logic                               outside
);
	import pip_pkg::*;

	logic [2*COORD_W-1:0] mem [MAX_VERTICES];

	logic signed [COORD_W-1:0] px_q, py_q;
	logic                      outside_q;

	logic [2*COORD_W-1:0]      rdata_s1;
	logic                      v_s1, e_s1;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;

	logic signed [COORD_W-1:0] cur_x, cur_y;
	logic                      straddle;

	logic                     v_s2, live_s2;
	logic signed [DIFF_W-1:0] dx1_s2, dx2_s2, dy1_s2, dy2_s2;

	logic                     v_s3, live_s3;
	logic signed [PROD_W-1:0] p1_s3, p2_s3;
	logic                     m1neg_s3, m2neg_s3, dy2neg_s3;

	logic                     toggle;

	assign cur_x    = rdata_s1[2*COORD_W-1:COORD_W];
	assign cur_y    = rdata_s1[COORD_W-1:0];
	assign straddle = (cur_y > py_q) != (prev_y_q > py_q);

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= {coord_x, coord_y};
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Crossing decision; a zero difference counts as positive
	always_comb begin
		toggle = 1'b0;
		if (live_s3) begin
			if (dy2neg_s3) begin
				if (!m1neg_s3 && m2neg_s3) begin
					toggle = 1'b1;
				end else if (m1neg_s3 == m2neg_s3) begin
					toggle = p1_s3 > p2_s3;
				end
			end else begin
				if (m1neg_s3 && !m2neg_s3) begin
					toggle = 1'b1;
				end else if (m1neg_s3 == m2neg_s3) begin
					toggle = p1_s3 < p2_s3;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_query) begin
			px_q      <= coord_x;
			py_q      <= coord_y;
			outside_q <= 1'b1;
		end else if (toggle) begin
			outside_q <= ~outside_q;
		end

		e_s1 <= cmd.rd_edge;

		if (v_s1) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end

		live_s2 <= v_s1 && e_s1 && straddle;
		dx1_s2  <= {px_q[COORD_W-1], px_q} - {cur_x[COORD_W-1], cur_x};
		dx2_s2  <= {prev_x_q[COORD_W-1], prev_x_q} - {cur_x[COORD_W-1], cur_x};
		dy1_s2  <= {py_q[COORD_W-1], py_q} - {cur_y[COORD_W-1], cur_y};
		dy2_s2  <= {prev_y_q[COORD_W-1], prev_y_q} - {cur_y[COORD_W-1], cur_y};

		live_s3   <= v_s2 && live_s2;
		p1_s3     <= dx1_s2 * dy2_s2;
		p2_s3     <= dx2_s2 * dy1_s2;
		m1neg_s3  <= dx1_s2[DIFF_W-1] ^ dy2_s2[DIFF_W-1];
		m2neg_s3  <= dx2_s2[DIFF_W-1] ^ dy1_s2[DIFF_W-1];
		dy2neg_s3 <= dy2_s2[DIFF_W-1];
	end

	assign stat.pipe_busy = v_s1 | v_s2 | v_s3;
	assign outside        = outside_q;

endmodule

[design/pip_ctrl.sv]
// ----------------------------------------------------------------------------
// pip_ctrl
// Command decode, vertex count register and the query sequencer that walks
// the vertex store once around the polygon.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pip_ctrl #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
	parameter int AW           = $clog2(MAX_VERTICES),
	parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      opcode,
	input  logic [pip_pkg::IDX_W-1:0] vertex_index,
	input  logic                      config_write,
	input  logic [pip_pkg::CNT_W-1:0] config_data,
	input  pip_pkg::pip_stat_t        stat,
	output logic                      busy,
	output logic                      done,
	output pip_pkg::pip_cmd_t         cmd,
	output logic [AW-1:0]             wr_addr,
	output logic [AW-1:0]             rd_addr
);
	import pip_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		READ,
		DRAIN
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     k_q;
	logic              done_q;
	logic [NW-1:0]     n_eff;
	logic              accept;

	assign accept  = start && (state_q == IDLE);
	assign n_eff   = (int'(count_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_q);
	assign wr_addr = AW'(vertex_index);

	// First read fetches the closing vertex n-1, then 0..n-1
	assign rd_addr = (k_q == '0) ? AW'(n_q - NW'(1)) : AW'(k_q - NW'(1));

	assign cmd.start_query = accept && (opcode == OP_QUERY);
	assign cmd.wr_en       = accept && (opcode == OP_LOAD) &&
	                         (int'(vertex_index) < MAX_VERTICES);
	assign cmd.rd_en       = (state_q == READ);
	assign cmd.rd_edge     = (state_q == READ) && (k_q != '0);

	assign busy = (state_q != IDLE);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
			n_q     <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (config_write) begin
				count_q <= config_data;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd.start_query) begin
						n_q     <= n_eff;
						k_q     <= '0;
						state_q <= (n_eff == '0) ? DRAIN : READ;
					end
				end
				READ: begin
					k_q <= k_q + NW'(1);
					if (k_q == n_q) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					// hold until the last edge has updated the flag
					if (!stat.pipe_busy) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`ASSERT_NEXT(a_query_busy, cmd.start_query, busy, "query accepted but block not busy")
	`ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")
	`ASSERT_IMPLIES(a_rd_in_range, cmd.rd_en, (NW'(rd_addr) < n_q), "read beyond polygon")
	`ASSERT_IMPLIES(a_done_quiet, done, !stat.pipe_busy && !busy, "result with work in flight")

endmodule

[design/point_in_polygon_test.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number geofence test over a stored polygon of up to MAX_VERTICES
// vertices.
// ----------------------------------------------------------------------------
// A load item (opcode 0) writes one vertex in the cycle it is accepted and
// leaves busy low, so loads may follow every cycle. A query item (opcode 1)
// walks the polygon through the vertex store's single read port, one vertex a
// cycle: n + 1 reads, where n is vertex_count saturated to MAX_VERTICES. Each
// edge then passes the difference and product stages before it toggles the
// outside flag. done pulses for one cycle with outside valid once the last
// edge has left the pipeline; the next item can be accepted while done is
// high. The receiver cannot stall: sample outside whenever done is high.
// Write config_data only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
	parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               opcode,
	input  logic [pip_pkg::IDX_W-1:0]          vertex_index,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
	input  logic                               config_write,
	input  logic [pip_pkg::CNT_W-1:0]          config_data,
	output logic                               done,
	output logic                               outside
);
	import pip_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	pip_cmd_t      cmd;
	pip_stat_t     stat;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	pip_ctrl #(
		.MAX_VERTICES (MAX_VERTICES),
		.AW           (AW),
		.NW           (NW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (opcode),
		.vertex_index (vertex_index),
		.config_write (config_write),
		.config_data  (config_data),
		.stat         (stat),
		.busy         (busy),
		.done         (done),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr)
	);

	pip_datapath #(
		.MAX_VERTICES (MAX_VERTICES),
		.AW           (AW)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.coord_x (coord_x),
		.coord_y (coord_y),
		.stat    (stat),
		.outside (outside)
	);

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: point-in-polygon geofence testbench
// Loads polygons into the vertex store, sets the vertex count between phases
// and checks every query answer against a crossing-number predictor kept in
// a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pip_pkg::*;

	localparam int MAXV          = MAX_VERTICES_DEF;
	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 2000;
	localparam int TARGET_ITEMS  = 1050;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef enum {SPAN_TINY, SPAN_MID, SPAN_FULL} span_t;

	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	class fence_tracker_t;
		coord_t           vx[MAXV];
		coord_t           vy[MAXV];
		logic [CNT_W-1:0] vertex_count;
		bit               outside_q[$];
		int               errors;

		function new();
			vertex_count = '0;
			errors = 0;
			foreach (vx[k]) begin
				vx[k] = '0;
				vy[k] = '0;
			end
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		function int sign_of(longint v);
			return (v < 0) ? -1 : 1;
		endfunction

		// Crossing-number walk; zero differences count as positive.
		function bit predict_outside(coord_t px, coord_t py);
			int     n;
			int     j;
			longint xi, yi, xj, yj, dx1, dx2, dy1, dy2;
			int     m1, m2;
			bit     flip;
			bit     res;
			n = (vertex_count > MAXV) ? MAXV : int'(vertex_count);
			if (n == 0) begin
				return 1'b1;
			end
			res = 1'b1;
			j = n - 1;
			for (int i = 0; i < n; i++) begin
				xi = vx[i];
				yi = vy[i];
				xj = vx[j];
				yj = vy[j];
				if ((yi > py) != (yj > py)) begin
					dx1 = longint'(px) - xi;
					dx2 = xj - xi;
					dy1 = longint'(py) - yi;
					dy2 = yj - yi;
					m1 = sign_of(dx1) * sign_of(dy2);
					m2 = sign_of(dx2) * sign_of(dy1);
					if (dy2 < 0) begin
						flip = (m1 > m2) || (m1 == m2 && dx1 * dy2 > dx2 * dy1);
					end else begin
						flip = (m1 < m2) || (m1 == m2 && dx1 * dy2 < dx2 * dy1);
					end
					if (flip) begin
						res = !res;
					end
				end
				j = i;
			end
			return res;
		endfunction

		function void note_item(logic op, logic [IDX_W-1:0] idx, coord_t x, coord_t y);
			if (op == OP_LOAD) begin
				if (idx < MAXV) begin
					vx[idx] = x;
					vy[idx] = y;
				end
			end else begin
				outside_q.push_back(predict_outside(x, y));
			end
		endfunction

		function void check_outside(logic got);
			bit want;
			if (outside_q.size() == 0) begin
				flag($sformatf("unexpected result: outside=%b", got));
				return;
			end
			want = outside_q.pop_front();
			if (got !== want) begin
				flag($sformatf("outside mismatch: expected %b, got %b", want, got));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               opcode = OP_LOAD;
	logic [IDX_W-1:0]   vertex_index = '0;
	coord_t             coord_x = '0;
	coord_t             coord_y = '0;
	logic               config_write = 1'b0;
	logic [CNT_W-1:0]   config_data = '0;
	logic               done;
	logic               outside;

	fence_tracker_t board = new();
	int             items_sent = 0;
	int             stall_cycles = 0;
	bit             steady = 1'b0;

	point_in_polygon_test #(
		.MAX_VERTICES(MAXV)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.config_write (config_write),
		.config_data  (config_data),
		.done         (done),
		.outside      (outside)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_outside(outside);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic coord_t rand_coord(span_t span);
		if ($urandom_range(0, 15) == 0) begin
			case ($urandom_range(0, 3))
				0: return COORD_MIN;
				1: return COORD_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		case (span)
			SPAN_TINY: return coord_t'(int'($urandom_range(0, 16)) - 8);
			SPAN_MID:  return coord_t'(int'($urandom_range(0, 2000)) - 1000);
			default:   return coord_t'($urandom);
		endcase
	endfunction

	// Hold start high across back-to-back items; lower it only for a gap.
	task automatic send_item(logic op, logic [IDX_W-1:0] idx, coord_t x, coord_t y);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50) begin
			gap = 0;
		end else if (r < 85) begin
			gap = $urandom_range(1, 3);
		end else if (r < 97) begin
			gap = $urandom_range(4, 10);
		end else begin
			gap = $urandom_range(20, 60);
		end
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		opcode = op;
		vertex_index = idx;
		coord_x = x;
		coord_y = y;
		do begin
			@(posedge clk);
		end while (busy);
		board.note_item(op, idx, x, y);
		items_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (board.outside_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_vertex_count(int cnt);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		config_write = 1'b1;
		config_data = CNT_W'(cnt);
		board.vertex_count = CNT_W'(cnt);
		@(negedge clk);
		config_write = 1'b0;
	endtask

	initial begin
		int     cnt;
		int     n_eff;
		int     nq;
		int     k;
		int     r;
		span_t  span;
		coord_t px;
		coord_t py;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty polygon right after reset: outside regardless of the point.
		send_item(OP_QUERY, 4'($urandom), '0, '0);

		// Full-range square in the first four slots, random vertices elsewhere.
		send_item(OP_LOAD, 4'd0, COORD_MIN, COORD_MIN);
		send_item(OP_LOAD, 4'd1, COORD_MAX, COORD_MIN);
		send_item(OP_LOAD, 4'd2, COORD_MAX, COORD_MAX);
		send_item(OP_LOAD, 4'd3, COORD_MIN, COORD_MAX);
		for (k = 4; k < MAXV; k++) begin
			send_item(OP_LOAD, IDX_W'(k), rand_coord(SPAN_FULL), rand_coord(SPAN_FULL));
		end

		set_vertex_count(4);
		send_item(OP_QUERY, 4'($urandom), '0, '0);
		send_item(OP_QUERY, 4'($urandom), COORD_MIN, '0);
		send_item(OP_QUERY, 4'($urandom), COORD_MAX, '0);
		send_item(OP_QUERY, 4'($urandom), '0, COORD_MIN);
		send_item(OP_QUERY, 4'($urandom), COORD_MAX, COORD_MAX);

		// Count above capacity saturates to the full store.
		set_vertex_count(31);
		send_item(OP_QUERY, 4'($urandom), '0, '0);
		send_item(OP_QUERY, 4'($urandom), COORD_MAX, COORD_MIN);
		set_vertex_count(16);
		send_item(OP_QUERY, 4'($urandom), '1, '0);

		while (items_sent < TARGET_ITEMS) begin
			r = $urandom_range(0, 19);
			case (r)
				0: cnt = 0;
				1: cnt = 16;
				2: cnt = $urandom_range(17, 31);
				3: cnt = 1;
				4: cnt = 2;
				default: cnt = $urandom_range(3, 16);
			endcase
			n_eff = (cnt > MAXV) ? MAXV : cnt;
			span = span_t'($urandom_range(0, 2));
			steady = ($urandom_range(0, 3) == 0);
			set_vertex_count(cnt);

			for (k = 0; k < n_eff; k++) begin
				send_item(OP_LOAD, IDX_W'(k), rand_coord(span), rand_coord(span));
			end

			nq = $urandom_range(6, 20);
			repeat (nq) begin
				// Stray load into any slot; every slot already holds a vertex.
				if ($urandom_range(0, 9) == 0) begin
					send_item(OP_LOAD, 4'($urandom), rand_coord(span), rand_coord(span));
				end
				k = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
				r = (n_eff > 0) ? $urandom_range(0, 4) : $urandom_range(3, 4);
				case (r)
					0: begin
						px = board.vx[k];
						py = board.vy[k];
					end
					1: begin
						px = rand_coord(span);
						py = board.vy[k];
					end
					2: begin
						cnt = (k == 0) ? n_eff - 1 : k - 1;
						px = coord_t'((longint'(board.vx[k]) + longint'(board.vx[cnt])) / 2);
						py = coord_t'((longint'(board.vy[k]) + longint'(board.vy[cnt])) / 2);
					end
					3: begin
						px = rand_coord(span);
						py = rand_coord(span);
					end
					default: begin
						px = rand_coord(SPAN_FULL);
						py = rand_coord(SPAN_FULL);
					end
				endcase
				send_item(OP_QUERY, 4'($urandom), px, py);
				if ($urandom_range(0, 9) == 0) begin
					drain_results();
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outside_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
